// File: design/fbcr_pkg.sv
package fbcr_pkg;

    // Default display geometry
    localparam int DISP_WIDTH_DEF    = 128;
    localparam int DISP_HEIGHT_DEF   = 64;
    localparam int WORDS_PER_ROW_DEF = 8;

    // Field and datapath widths
    localparam int WORD_W    = 16;  // framebuffer word
    localparam int PIX_SHIFT = 4;   // log2 of pixels per word
    localparam int PIX_MSB   = 15;  // bit of the leftmost pixel
    localparam int OP_W      = 2;
    localparam int CRD_W     = 10;  // coordinate and radius fields
    localparam int COL_W     = 6;   // word column field
    localparam int WCOL_W    = 7;   // word column of a signed point
    localparam int PT_W      = 12;  // signed point coordinate
    localparam int AB_W      = 11;  // circle step counters
    localparam int D_W       = 16;  // midpoint decision variable
    localparam int ROWB_W    = 17;  // address arithmetic
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 24;

    // Midpoint rule constants
    localparam logic signed [D_W-1:0] D_INIT   = 16'sd3;
    localparam logic signed [D_W-1:0] D_INC_A  = 16'sd6;
    localparam logic signed [D_W-1:0] D_INC_AB = 16'sd10;

    localparam logic [WORD_W-1:0] PIX_ONE = 16'h0001;

    typedef enum logic [OP_W-1:0] {
        OP_PLOT   = 2'd0,
        OP_CIRCLE = 2'd1,
        OP_READ   = 2'd2,
        OP_FILL   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISP,
        ST_CCHK,
        ST_SEL,
        ST_ADDR,
        ST_RD,
        ST_WR,
        ST_FILL,
        ST_RESP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;
        logic circ_init;
        logic circ_adv;
        logic k_clr;
        logic k_inc;
        logic sel_pt;
        logic calc_addr;
        logic mem_rd;
        logic pix_we;
        logic fill_we;
        logic fill_zero;
        logic sweep_clr;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic circ_done;
        logic k_last;
        logic ok;
        logic sweep_last;
        logic out_free;
    } sts_t;

    // Bit mask of one pixel inside its word, leftmost pixel in the MSB
    function automatic logic [WORD_W-1:0] pix_mask(input logic [PIX_SHIFT-1:0] xb);
        return PIX_ONE << (4'(PIX_MSB) - xb);
    endfunction

endpackage

// File: design/fbcr_ctrl.sv
module fbcr_ctrl import fbcr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.fill_we   = 1'b1;
                cmd.fill_zero = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (sts.op)
                    OP_PLOT: begin
                        state_next = ST_SEL;
                    end
                    OP_CIRCLE: begin
                        cmd.circ_init = 1'b1;
                        state_next    = ST_CCHK;
                    end
                    OP_READ: begin
                        state_next = ST_ADDR;
                    end
                    OP_FILL: begin
                        cmd.sweep_clr = 1'b1;
                        state_next    = ST_FILL;
                    end
                endcase
            end
            ST_CCHK: begin
                if (sts.circ_done) begin
                    state_next = ST_RESP;
                end else begin
                    cmd.k_clr  = 1'b1;
                    state_next = ST_SEL;
                end
            end
            ST_SEL: begin
                cmd.sel_pt = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.calc_addr = 1'b1;
                state_next    = ST_RD;
            end
            ST_RD: begin
                if (sts.ok) begin
                    cmd.mem_rd = 1'b1;
                    state_next = (sts.op == OP_READ) ? ST_RESP : ST_WR;
                end else if (sts.op != OP_CIRCLE) begin
                    state_next = ST_RESP;
                end else if (sts.k_last) begin
                    // dropped point, last of this step
                    cmd.circ_adv = 1'b1;
                    state_next   = ST_CCHK;
                end else begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_SEL;
                end
            end
            ST_WR: begin
                cmd.pix_we = 1'b1;
                if (sts.op != OP_CIRCLE) begin
                    state_next = ST_RESP;
                end else if (sts.k_last) begin
                    cmd.circ_adv = 1'b1;
                    state_next   = ST_CCHK;
                end else begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_SEL;
                end
            end
            ST_FILL: begin
                cmd.fill_we = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/fbcr_dpath.sv
module fbcr_dpath import fbcr_pkg::*; #(
    parameter int DISP_WIDTH    = DISP_WIDTH_DEF,
    parameter int DISP_HEIGHT   = DISP_HEIGHT_DEF,
    parameter int WORDS_PER_ROW = WORDS_PER_ROW_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int DEPTH = DISP_HEIGHT * WORDS_PER_ROW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic signed [PT_W-1:0] W_S = PT_W'(DISP_WIDTH);
    localparam logic signed [PT_W-1:0] H_S = PT_W'(DISP_HEIGHT);
    localparam logic [WCOL_W-1:0]      WPR_C = WCOL_W'(WORDS_PER_ROW);
    localparam logic [ROWB_W-1:0]      WPR_M = ROWB_W'(WORDS_PER_ROW);
    localparam logic [AW-1:0]          LAST_A = AW'(DEPTH - 1);

    // Request word
    op_t               op_reg;
    logic [CRD_W-1:0]  x_reg;
    logic [CRD_W-1:0]  y_reg;
    logic [CRD_W-1:0]  r_reg;
    logic              on_reg;
    logic [COL_W-1:0]  col_reg;

    // Circle stepping
    logic [AB_W-1:0]        a_reg;
    logic [AB_W-1:0]        b_reg;
    logic signed [D_W-1:0]  d_reg;
    logic [2:0]             k_reg;

    // Point and address stages
    logic signed [PT_W-1:0] pt_x_reg;
    logic signed [PT_W-1:0] pt_y_reg;
    logic                   emit_reg;
    logic [AW-1:0]          addr_reg;
    logic                   ok_reg;
    logic [WORD_W-1:0]      mask_reg;

    // Store and sweep
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic [AW-1:0]     cnt_reg;

    // Output register
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_data_reg;
    logic              out_inr_reg;

    // Combinational nets
    logic signed [D_W-1:0]  a_ext;
    logic signed [D_W-1:0]  b_ext;
    logic signed [D_W-1:0]  r_ext;
    logic signed [D_W-1:0]  d_neg;
    logic signed [D_W-1:0]  d_pos;
    logic signed [PT_W-1:0] cx_s;
    logic signed [PT_W-1:0] cy_s;
    logic signed [PT_W-1:0] a_s;
    logic signed [PT_W-1:0] b_s;
    logic signed [PT_W-1:0] cpt_x;
    logic signed [PT_W-1:0] cpt_y;
    logic                   cpt_emit;
    logic                   a_nz;
    logic                   a_ne_b;
    logic [WCOL_W-1:0]      pt_col;
    logic                   plot_ok;
    logic                   read_ok;
    logic [ROWB_W-1:0]      plot_base;
    logic [ROWB_W-1:0]      read_base;
    logic                   pix_val;
    logic [WORD_W-1:0]      pix_data;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [WORD_W-1:0]      wdata;

    // Latch the accepted request word
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            op_reg  <= op_t'(s_tdata[1:0]);
            x_reg   <= s_tdata[11:2];
            y_reg   <= s_tdata[21:12];
            r_reg   <= s_tdata[31:22];
            on_reg  <= s_tdata[32];
            col_reg <= s_tdata[38:33];
        end
    end

    // Midpoint decision update
    assign a_ext = {{(D_W-AB_W){1'b0}}, a_reg};
    assign b_ext = {{(D_W-AB_W){1'b0}}, b_reg};
    assign r_ext = {{(D_W-CRD_W){1'b0}}, r_reg};
    assign d_neg = d_reg + (a_ext <<< 2) + D_INC_A;
    assign d_pos = d_reg + ((a_ext - b_ext) <<< 2) + D_INC_AB;

    always_ff @(posedge aclk) begin
        if (cmd.circ_init) begin
            a_reg <= '0;
            b_reg <= {1'b0, r_reg};
            d_reg <= D_INIT - (r_ext <<< 1);
        end else if (cmd.circ_adv) begin
            a_reg <= a_reg + 1'b1;
            if (d_reg[D_W-1]) begin
                d_reg <= d_neg;
            end else begin
                d_reg <= d_pos;
                b_reg <= b_reg - 1'b1;
            end
        end
        if (cmd.k_clr) begin
            k_reg <= '0;
        end else if (cmd.k_inc) begin
            k_reg <= k_reg + 1'b1;
        end
    end

    // Octant point k of the current step, with axis and diagonal duplicates masked
    assign cx_s   = {2'b00, x_reg};
    assign cy_s   = {2'b00, y_reg};
    assign a_s    = {1'b0, a_reg};
    assign b_s    = {1'b0, b_reg};
    assign a_nz   = (a_reg != '0);
    assign a_ne_b = (a_reg != b_reg);

    always_comb begin
        unique case (k_reg)
            3'd0: begin cpt_x = cx_s - b_s; cpt_y = cy_s - a_s; cpt_emit = 1'b1; end
            3'd1: begin cpt_x = cx_s + b_s; cpt_y = cy_s - a_s; cpt_emit = 1'b1; end
            3'd2: begin cpt_x = cx_s - b_s; cpt_y = cy_s + a_s; cpt_emit = a_nz; end
            3'd3: begin cpt_x = cx_s + b_s; cpt_y = cy_s + a_s; cpt_emit = a_nz; end
            3'd4: begin cpt_x = cx_s - a_s; cpt_y = cy_s - b_s; cpt_emit = a_ne_b; end
            3'd5: begin cpt_x = cx_s + a_s; cpt_y = cy_s - b_s; cpt_emit = a_ne_b & a_nz; end
            3'd6: begin cpt_x = cx_s - a_s; cpt_y = cy_s + b_s; cpt_emit = a_ne_b; end
            3'd7: begin cpt_x = cx_s + a_s; cpt_y = cy_s + b_s; cpt_emit = a_ne_b & a_nz; end
        endcase
    end

    // Point select stage
    always_ff @(posedge aclk) begin
        if (cmd.sel_pt) begin
            if (op_reg == OP_CIRCLE) begin
                pt_x_reg <= cpt_x;
                pt_y_reg <= cpt_y;
                emit_reg <= cpt_emit;
            end else begin
                pt_x_reg <= cx_s;
                pt_y_reg <= cy_s;
                emit_reg <= 1'b1;
            end
        end
    end

    // Range check and word address
    assign pt_col  = pt_x_reg[PT_W-2:PIX_SHIFT];
    assign plot_ok = emit_reg && !pt_x_reg[PT_W-1] && !pt_y_reg[PT_W-1]
                     && (pt_x_reg < W_S) && (pt_y_reg < H_S) && (pt_col < WPR_C);
    assign read_ok = ({2'b00, y_reg} < H_S) && ({1'b0, col_reg} < WPR_C);
    assign plot_base = ROWB_W'(pt_y_reg[CRD_W-1:0]) * WPR_M + ROWB_W'(pt_col);
    assign read_base = ROWB_W'(y_reg) * WPR_M + ROWB_W'(col_reg);

    always_ff @(posedge aclk) begin
        if (cmd.calc_addr) begin
            if (op_reg == OP_READ) begin
                addr_reg <= read_base[AW-1:0];
                ok_reg   <= read_ok;
            end else begin
                addr_reg <= plot_base[AW-1:0];
                ok_reg   <= plot_ok;
            end
            mask_reg <= pix_mask(pt_x_reg[PIX_SHIFT-1:0]);
        end
    end

    // Write port: pixel read-modify-write or sweep
    assign pix_val  = (op_reg == OP_CIRCLE) | on_reg;
    assign pix_data = pix_val ? (rdata_reg | mask_reg) : (rdata_reg & ~mask_reg);
    assign we       = cmd.pix_we | cmd.fill_we;
    assign waddr    = cmd.fill_we ? cnt_reg : addr_reg;
    assign wdata    = cmd.fill_we ? {WORD_W{on_reg & ~cmd.fill_zero}} : pix_data;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[addr_reg];
        end
    end

    // Sweep address counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.sweep_clr) begin
            cnt_reg <= '0;
        end else if (cmd.fill_we) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= ((op_reg == OP_READ) && ok_reg) ? rdata_reg : '0;
            out_inr_reg  <= ((op_reg == OP_READ) || (op_reg == OP_PLOT)) && ok_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-WORD_W-1){1'b0}}, out_inr_reg, out_data_reg};

    // Status to controller; b wraps below zero only after a zero radius
    assign sts.op         = op_reg;
    assign sts.circ_done  = (a_reg > b_reg) || b_reg[AB_W-1];
    assign sts.k_last     = &k_reg;
    assign sts.ok         = ok_reg;
    assign sts.sweep_last = (cnt_reg == LAST_A);
    assign sts.out_free   = !out_valid_reg || m_tready;

endmodule

// File: design/framebuffer_circle_raster_unit.sv
// Plot and circle points are drawn by read-modify-write of one store word; points off the
// display are dropped without a write. Circle: about 1 + 0.7*radius steps, each drawing up to
// eight octant points in turn. Fill writes every word of the store.
// One request in flight; a new word is taken while the result waits.
// Reset (aresetn low, synchronous) starts a clearing pass over the
// DISP_HEIGHT*WORDS_PER_ROW words of the store (512 at default size) before s_tready rises.
module framebuffer_circle_raster_unit import fbcr_pkg::*; #(
    parameter int DISP_WIDTH    = DISP_WIDTH_DEF,
    parameter int DISP_HEIGHT   = DISP_HEIGHT_DEF,
    parameter int WORDS_PER_ROW = WORDS_PER_ROW_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // op[1:0], pos_x[11:2], pos_y[21:12], radius[31:22], pixel_on[32], word_col[38:33]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // read_data[15:0], in_range[16]
    output logic [M_DATA_W-1:0] m_tdata
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    fbcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Store, circle stepper and result register
    fbcr_dpath #(
        .DISP_WIDTH    (DISP_WIDTH),
        .DISP_HEIGHT   (DISP_HEIGHT),
        .WORDS_PER_ROW (WORDS_PER_ROW)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
